@@ sv/lps_pkg.sv @@
// lps_pkg: shared types, codes and constants of the led pattern sequencer
// no dependencies; used by lps_out_if, the debouncer, the core and the testbench
package lps_pkg;

    localparam int unsigned FastWidth = 16;
    localparam int unsigned DebWidth  = 8;
    localparam int unsigned CfgWidth  = 16;
    localparam int unsigned CfgIdxWidth = 2;

    typedef logic [7:0] t_led;
    typedef logic [1:0] t_mode;
    typedef logic [2:0] t_sweep_idx;
    typedef logic [FastWidth-1:0] t_ticks;
    typedef logic [DebWidth-1:0] t_deb;

    // register indexes of the configuration port
    localparam logic [CfgIdxWidth-1:0] CFG_FAST_STEP = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_SLOW_STEP = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_DEBOUNCE  = 2'd2;

    localparam t_ticks FAST_STEP_RESET = 16'd100;
    localparam t_ticks SLOW_STEP_RESET = 16'd200;
    localparam t_deb   DEBOUNCE_RESET  = 8'd5;

    // pattern modes
    localparam t_mode MODE_WALK   = 2'd0;
    localparam t_mode MODE_ALT    = 2'd1;
    localparam t_mode MODE_BOUNCE = 2'd2;

    localparam t_led LED_OFF    = 8'hFF;
    localparam t_led WALK_RESET = 8'h01;
    localparam t_led ALT_A      = 8'h55;
    localparam t_led ALT_B      = 8'hAA;

    localparam t_sweep_idx SWEEP_LAST = 3'd6;

    // bounce sweep, out-of-range index reads the first entry
    function automatic t_led sweep_entry(input t_sweep_idx idx);
        t_led v;
        case (idx)
            3'd0: v = 8'h7E;
            3'd1: v = 8'hBD;
            3'd2: v = 8'hDB;
            3'd3: v = 8'hE7;
            3'd4: v = 8'hDB;
            3'd5: v = 8'hBD;
            3'd6: v = 8'h7E;
            default: v = 8'h7E;
        endcase
        return v;
    endfunction

endpackage

@@ sv/lps_in_if.sv @@
// lps_in_if: tick request channel carrying the two active-low button levels
// depends on nothing
interface lps_in_if;
    logic valid;
    logic ready;
    logic run_button;
    logic mode_button;

    modport source (output valid, output run_button, output mode_button, input ready);
    modport sink   (input valid, input run_button, input mode_button, output ready);
endinterface

@@ sv/lps_out_if.sv @@
// lps_out_if: result request channel with led drive, run flag and mode
// depends on lps_pkg
interface lps_out_if
    import lps_pkg::*;
;
    logic  valid;
    logic  ready;
    t_led  led_drive;
    logic  running;
    t_mode current_mode;

    modport source (output valid, output led_drive, output running, output current_mode,
                    input ready);
    modport sink   (input valid, input led_drive, input running, input current_mode,
                    output ready);
endinterface

@@ sv/led_pattern_sequencer_core.sv @@
// led_pattern_sequencer_core: top level of the led chaser pattern generator
// depends on lps_pkg, lps_in_if, lps_out_if and lps_debounce
//
//  channel   dir   payload                              accepted when
//  i_tick    in    run_button, mode_button              valid && ready
//  o_led     out   led_drive, running, current_mode     valid && ready
//  cfg       in    i_cfg_idx, i_cfg_data                i_cfg_we
//
// one tick request is taken per clock if i_tick.ready is high, one result per
// tick; all state updates in a single pass between the accepted tick and the
// result register; a held result does not stop intake while the sink takes it
// i_tick.ready drops only while a result waits and o_led.ready is low
// synchronous active-low reset restores the documented reset state at once
module led_pattern_sequencer_core
    import lps_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CfgIdxWidth-1:0] i_cfg_idx,
    input  logic [CfgWidth-1:0]    i_cfg_data,
    lps_in_if.sink                 i_tick,
    lps_out_if.source              o_led
);

    // configuration registers
    t_ticks r_fast, r_slow;
    t_deb   r_deb;

    // sequencer state
    logic       r_run, n_run;
    t_mode      r_mode, n_mode;
    t_led       r_walk, n_walk;
    t_led       r_alt, n_alt;
    t_sweep_idx r_idx, n_idx;
    t_ticks     r_timer, n_timer;
    logic       r_sip, n_sip;
    t_led       r_led, n_led;

    // result register
    logic  r_ovalid;
    t_led  r_oled;
    logic  r_orun;
    t_mode r_omode;

    logic accept;
    logic pend_run, pend_mode;
    logic boundary, mid_sweep, consume;
    logic [FastWidth-1:0] step_len;
    t_led walk_shift;
    logic [3:0] idx_inc;

    assign i_tick.ready = !r_ovalid || o_led.ready;
    assign accept       = i_tick.valid && i_tick.ready;

    // events are applied only at a step boundary, and while running in bounce
    // mode only once the sweep is back at its first entry
    assign boundary  = !r_sip;
    assign mid_sweep = r_run && (r_mode == MODE_BOUNCE) && (r_idx != '0);
    assign consume   = boundary && !mid_sweep;

    lps_debounce u_run_key (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (accept),
        .i_level   (i_tick.run_button),
        .i_need    (r_deb),
        .i_consume (consume),
        .o_pending (pend_run)
    );

    lps_debounce u_mode_key (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (accept),
        .i_level   (i_tick.mode_button),
        .i_need    (r_deb),
        .i_consume (consume),
        .o_pending (pend_mode)
    );

    assign walk_shift = {r_walk[6:0], 1'b0};
    assign idx_inc    = {1'b0, r_idx} + 4'd1;

    always_comb begin
        n_run   = r_run;
        n_mode  = r_mode;
        n_walk  = r_walk;
        n_alt   = r_alt;
        n_idx   = r_idx;
        n_timer = r_timer;
        n_sip   = r_sip;
        n_led   = r_led;
        step_len = r_fast;

        if (boundary) begin
            if (consume) begin
                // run toggle first, then the mode change
                if (pend_run) n_run = !r_run;
                if (pend_mode) n_mode = (r_mode >= MODE_BOUNCE) ? MODE_WALK
                                                                : r_mode + t_mode'(1);
            end
            if (n_run) begin
                case (n_mode)
                    MODE_WALK: begin
                        n_led  = ~r_walk;
                        n_walk = (walk_shift == '0) ? WALK_RESET : walk_shift;
                    end
                    MODE_ALT: begin
                        n_led    = r_alt;
                        n_alt    = (r_alt == ALT_A) ? ALT_B : ALT_A;
                        step_len = r_slow;
                    end
                    MODE_BOUNCE: begin
                        n_led = sweep_entry(r_idx);
                        n_idx = (idx_inc > {1'b0, SWEEP_LAST}) ? '0 : idx_inc[2:0];
                    end
                    default: n_led = LED_OFF;
                endcase
                // zero step length counts as one tick; this tick is the first
                n_timer = (step_len == '0) ? '0 : step_len - t_ticks'(1);
                n_sip   = (n_timer != '0);
            end else begin
                n_led = LED_OFF;
            end
        end else begin
            n_timer = r_timer - t_ticks'(1);
            n_sip   = (n_timer != '0);
        end
    end

    // configuration writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast <= FAST_STEP_RESET;
            r_slow <= SLOW_STEP_RESET;
            r_deb  <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FAST_STEP: r_fast <= i_cfg_data[FastWidth-1:0];
                CFG_SLOW_STEP: r_slow <= i_cfg_data[FastWidth-1:0];
                CFG_DEBOUNCE:  r_deb  <= i_cfg_data[DebWidth-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_mode  <= MODE_WALK;
            r_walk  <= WALK_RESET;
            r_alt   <= ALT_A;
            r_idx   <= '0;
            r_timer <= '0;
            r_sip   <= 1'b0;
            r_led   <= LED_OFF;
        end else if (accept) begin
            r_run   <= n_run;
            r_mode  <= n_mode;
            r_walk  <= n_walk;
            r_alt   <= n_alt;
            r_idx   <= n_idx;
            r_timer <= n_timer;
            r_sip   <= n_sip;
            r_led   <= n_led;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (accept) begin
            r_ovalid <= 1'b1;
        end else if (o_led.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_oled  <= n_led;
            r_orun  <= n_run;
            r_omode <= n_mode;
        end
    end

    assign o_led.valid        = r_ovalid;
    assign o_led.led_drive    = r_oled;
    assign o_led.running      = r_orun;
    assign o_led.current_mode = r_omode;

endmodule

@@ sv/lps_debounce.sv @@
// lps_debounce: press/confirm/release debouncer for one active-low button
// depends on lps_pkg; instantiated twice by led_pattern_sequencer_core
module lps_debounce
    import lps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_level,
    input  t_deb i_need,
    input  logic i_consume,
    output logic o_pending
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_HELD = 2'd2;

    logic [1:0] r_phase, n_phase;
    t_deb       r_cnt, n_cnt;
    logic       r_pending, n_pending;
    t_deb       need;

    assign need = (i_need == '0) ? t_deb'(1) : i_need;

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_pending = r_pending;
        case (r_phase)
            PH_IDLE: begin
                if (!i_level) begin
                    n_phase = PH_WAIT;
                    n_cnt   = '0;
                end
            end
            PH_WAIT: begin
                if (r_cnt != '1) n_cnt = r_cnt + t_deb'(1);
                if (n_cnt >= need) n_phase = i_level ? PH_IDLE : PH_HELD;
            end
            PH_HELD: begin
                if (i_level) begin
                    n_pending = 1'b1;
                    n_phase   = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // pending as seen by the step logic in this tick
    assign o_pending = i_en ? n_pending : r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cnt     <= '0;
            r_pending <= 1'b0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_pending <= n_pending & ~i_consume;
        end
    end

endmodule

@@ tb/testbench.sv @@
// testbench: self-checking bench for led_pattern_sequencer_core, one tick in, one result out
// depends on lps_pkg, lps_in_if and lps_out_if; holds its own model of the chaser in a class
module testbench
    import lps_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // index with no register behind it, writes there must change nothing
    localparam logic [CfgIdxWidth-1:0] CFG_UNUSED = 2'd3;
    // longest stretch without any request moving before the run is called hung
    localparam int unsigned STALL_LIMIT = 2000;
    // receiver back-pressure burst, long enough to fill the result register
    localparam int unsigned LONG_HOLD = 60;

    typedef enum logic [1:0] {
        KEY_IDLE = 2'd0,
        KEY_WAIT = 2'd1,
        KEY_HELD = 2'd2
    } t_key_phase;

    typedef struct packed {
        t_led  led;
        logic  running;
        t_mode mode;
    } t_led_result;

    // mirrors the chaser state tick by tick and keeps the results still owed
    class chaser_scoreboard;
        t_ticks     fast_len;
        t_ticks     slow_len;
        t_deb       deb_len;
        logic       run_flag;
        t_mode      mode;
        t_led       walk_bit;
        t_led       alt_pat;
        t_sweep_idx sweep_idx;
        t_ticks     step_left;
        logic       stepping;
        t_led       led_reg;
        t_key_phase key_phase [2];
        t_deb       key_cnt [2];
        logic       key_event [2];
        t_led       bounce_seq [7] = '{8'h7E, 8'hBD, 8'hDB, 8'hE7, 8'hDB, 8'hBD, 8'h7E};
        t_led_result expected_frames [$];
        int unsigned errors;

        function new();
            fast_len  = FAST_STEP_RESET;
            slow_len  = SLOW_STEP_RESET;
            deb_len   = DEBOUNCE_RESET;
            run_flag  = 1'b0;
            mode      = MODE_WALK;
            walk_bit  = WALK_RESET;
            alt_pat   = ALT_A;
            sweep_idx = '0;
            step_left = '0;
            stepping  = 1'b0;
            led_reg   = LED_OFF;
            errors    = 0;
            for (int k = 0; k < 2; k++) begin
                key_phase[k] = KEY_IDLE;
                key_cnt[k]   = '0;
                key_event[k] = 1'b0;
            end
        endfunction

        function void set_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] data);
            case (idx)
                CFG_FAST_STEP: fast_len = data;
                CFG_SLOW_STEP: slow_len = data;
                CFG_DEBOUNCE:  deb_len  = data[DebWidth-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_frames.size();
        endfunction

        // press must still be low at the confirm sample; event fires on release
        function void debounce_key(int k, logic level);
            t_deb need;
            need = (deb_len == 0) ? t_deb'(1) : deb_len;
            case (key_phase[k])
                KEY_IDLE: begin
                    if (!level) begin
                        key_phase[k] = KEY_WAIT;
                        key_cnt[k]   = '0;
                    end
                end
                KEY_WAIT: begin
                    if (key_cnt[k] != 8'hFF) key_cnt[k] = key_cnt[k] + 1'b1;
                    if (key_cnt[k] >= need) key_phase[k] = level ? KEY_IDLE : KEY_HELD;
                end
                KEY_HELD: begin
                    if (level) begin
                        key_event[k] = 1'b1;
                        key_phase[k] = KEY_IDLE;
                    end
                end
                default: key_phase[k] = KEY_IDLE;
            endcase
        endfunction

        function void begin_step();
            t_ticks len;
            len = fast_len;
            case (mode)
                MODE_WALK: begin
                    led_reg  = ~walk_bit;
                    walk_bit = walk_bit << 1;
                    if (walk_bit == 0) walk_bit = WALK_RESET;
                end
                MODE_ALT: begin
                    led_reg = alt_pat;
                    alt_pat = (alt_pat == ALT_A) ? ALT_B : ALT_A;
                    len     = slow_len;
                end
                MODE_BOUNCE: begin
                    led_reg   = (sweep_idx > SWEEP_LAST) ? bounce_seq[0] : bounce_seq[sweep_idx];
                    sweep_idx = (sweep_idx >= SWEEP_LAST) ? t_sweep_idx'(0) : sweep_idx + 1'b1;
                end
                default: led_reg = LED_OFF;
            endcase
            step_left = (len == 0) ? t_ticks'(1) : len;
            stepping  = 1'b1;
        endfunction

        // one accepted tick request gives exactly one expected result
        function void note_tick(logic run_b, logic mode_b);
            t_led_result r;
            debounce_key(0, run_b);
            debounce_key(1, mode_b);
            if (!stepping) begin
                // latched events wait for the end of a bounce sweep
                if (!(run_flag && mode == MODE_BOUNCE && sweep_idx != 0)) begin
                    if (key_event[0]) begin
                        run_flag     = !run_flag;
                        key_event[0] = 1'b0;
                    end
                    if (key_event[1]) begin
                        mode         = (mode >= MODE_BOUNCE) ? MODE_WALK : t_mode'(mode + 1'b1);
                        key_event[1] = 1'b0;
                    end
                end
                if (run_flag) begin_step();
                else led_reg = LED_OFF;
            end
            if (stepping) begin
                step_left = step_left - 1'b1;
                if (step_left == 0) stepping = 1'b0;
            end
            r.led     = led_reg;
            r.running = run_flag;
            r.mode    = mode;
            expected_frames.push_back(r);
        endfunction

        function void check_result(t_led led_v, logic run_v, t_mode mode_v);
            t_led_result want;
            if (expected_frames.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with nothing owed: led %02h running %0b mode %0d",
                             $realtime, led_v, run_v, mode_v);
                return;
            end
            want = expected_frames.pop_front();
            if (led_v !== want.led || run_v !== want.running || mode_v !== want.mode) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result mismatch: led %02h/%02h running %0b/%0b mode %0d/%0d %s",
                             $realtime, led_v, want.led, run_v, want.running, mode_v, want.mode,
                             "(got/expected)");
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CfgIdxWidth-1:0] i_cfg_idx;
    logic [CfgWidth-1:0]    i_cfg_data;

    lps_in_if  tick_if ();
    lps_out_if led_if ();

    led_pattern_sequencer_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tick     (tick_if),
        .o_led      (led_if)
    );

    chaser_scoreboard sb = new();

    // idle rates in percent, changed by the stimulus as the run goes on
    int unsigned send_idle_pct = 9;
    int unsigned recv_idle_pct = 64;
    int unsigned results_seen  = 0;
    int unsigned ticks_sent    = 0;

    // button waveform generator state: current level and ticks left at it
    bit          btn_level [2] = '{1'b1, 1'b1};
    int unsigned btn_dwell [2] = '{0, 0};
    int unsigned btn_gap_max   = 8;
    t_deb        cur_deb       = DEBOUNCE_RESET;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // monitor: results are checked before the tick of the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (led_if.valid && led_if.ready) begin
                sb.check_result(led_if.led_drive, led_if.running, led_if.current_mode);
                results_seen++;
            end
            if (tick_if.valid && tick_if.ready)
                sb.note_tick(tick_if.run_button, tick_if.mode_button);
        end
    end

    // watchdog: counts cycles in which no request moves on either channel
    initial begin
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((tick_if.valid && tick_if.ready) || (led_if.valid && led_if.ready) || !i_rst_n)
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $realtime, quiet);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver: random ready, plus one long hold while ticks keep coming
    initial begin
        int unsigned hold_left;
        bit          hold_armed;
        hold_left  = 0;
        hold_armed = 1'b1;
        led_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                led_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_armed && results_seen >= 300 && tick_if.valid) begin
                // sender is offering, so the block fills and must stall its input
                hold_armed = 1'b0;
                hold_left  = LONG_HOLD - 1;
                led_if.ready <= 1'b0;
            end else begin
                led_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // offer one tick request and wait until the block takes it
    task automatic push_tick(bit run_b, bit mode_b);
        while ($urandom_range(99) < send_idle_pct) begin
            tick_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        tick_if.valid       <= 1'b1;
        tick_if.run_button  <= run_b;
        tick_if.mode_button <= mode_b;
        do @(posedge i_clk); while (!tick_if.ready);
        @(negedge i_clk);
        ticks_sent++;
        // idle schedule: sender rarely idle first, then receiver, then neither
        if (ticks_sent < 633) begin
            send_idle_pct = 9;
            recv_idle_pct = 64;
        end else if (ticks_sent < 1266) begin
            send_idle_pct = 64;
            recv_idle_pct = 9;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    task automatic put_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    // registers change only once every owed result has been taken
    task automatic apply_settings(t_ticks fast, t_ticks slow, t_deb deb, bit poke_unused);
        tick_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        put_reg(CFG_FAST_STEP, fast);
        put_reg(CFG_SLOW_STEP, slow);
        put_reg(CFG_DEBOUNCE, CfgWidth'(deb));
        if (poke_unused) put_reg(CFG_UNUSED, 16'h0007);
        i_cfg_we <= 1'b0;
        cur_deb = deb;
    endtask

    // mostly presses long enough to confirm, some released before confirm
    function automatic bit next_level(int k);
        int unsigned need;
        need = (cur_deb == 0) ? 1 : cur_deb;
        if (btn_dwell[k] == 0) begin
            if (btn_level[k]) begin
                btn_level[k] = 1'b0;
                if ($urandom_range(9) < 7) btn_dwell[k] = need + 1 + $urandom_range(3);
                else btn_dwell[k] = $urandom_range(need, 1);
            end else begin
                btn_level[k] = 1'b1;
                btn_dwell[k] = $urandom_range(btn_gap_max, 1);
            end
        end
        btn_dwell[k]--;
        return btn_level[k];
    endfunction

    task automatic random_ticks(int unsigned count, int unsigned gap_max);
        bit run_b;
        bit mode_b;
        btn_gap_max = gap_max;
        repeat (count) begin
            run_b  = next_level(0);
            mode_b = next_level(1);
            push_tick(run_b, mode_b);
        end
    endtask

    initial begin
        // {run, mode} levels; with zero lengths every tick is a step boundary:
        // a press dropped before confirm, run on, mode to alternate, mode to bounce
        bit [1:0] seq_zero [13] = '{2'b11, 2'b00, 2'b11, 2'b01, 2'b01, 2'b11, 2'b10,
                                    2'b10, 2'b11, 2'b10, 2'b10, 2'b11, 2'b11};
        // long steps: mode event, two mode presses that merge, then run off
        bit [1:0] seq_merge [12] = '{2'b10, 2'b10, 2'b11, 2'b10, 2'b10, 2'b11,
                                     2'b10, 2'b10, 2'b11, 2'b01, 2'b01, 2'b11};

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_FAST_STEP;
        i_cfg_data          = '0;
        tick_if.valid       = 1'b0;
        tick_if.run_button  = 1'b1;
        tick_if.mode_button = 1'b1;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero step lengths and zero debounce act as one tick
        apply_settings(16'd0, 16'd0, 8'd0, 1'b0);
        foreach (seq_zero[j]) push_tick(seq_zero[j][1], seq_zero[j][0]);
        apply_settings(16'd20, 16'd3, 8'd1, 1'b0);
        foreach (seq_merge[j]) push_tick(seq_merge[j][1], seq_merge[j][0]);

        // random presses over a range of timings, extremes last
        apply_settings(16'd1, 16'd1, 8'd1, 1'b0);
        random_ticks(250, 6);
        apply_settings(16'd3, 16'd5, 8'd2, 1'b0);
        random_ticks(300, 12);
        apply_settings(16'd2, 16'd7, 8'd3, 1'b0);
        random_ticks(250, 20);
        apply_settings(FAST_STEP_RESET, SLOW_STEP_RESET, DEBOUNCE_RESET, 1'b0);
        random_ticks(300, 40);
        apply_settings(16'd1, 16'd2, 8'd255, 1'b0);
        random_ticks(520, 30);
        // write to the unused index must leave every register as it is
        apply_settings(16'd4, 16'd1, 8'd1, 1'b1);
        random_ticks(150, 8);
        // longest steps: events pile up behind a step that never ends here
        apply_settings(16'hFFFF, 16'hFFFF, 8'd1, 1'b0);
        random_ticks(60, 4);

        tick_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
